// ----- design/lgs_pkg.sv -----
// Shared types, constants and command structs of the life grid step core.
`timescale 1ns / 1ps

package lgs_pkg;

    // Default grid size.
    localparam int COLS_DEF = 22;
    localparam int ROWS_DEF = 16;

    // Fixed widths of the transaction fields.
    localparam int CMD_W = 2;
    localparam int COL_W = 5;
    localparam int ROW_W = 4;

    // Neighbor counts of the B3/S23 rule.
    localparam logic [3:0] LIFE_BIRTH   = 4'd3;
    localparam logic [3:0] LIFE_SURVIVE = 4'd2;

    // Command codes carried by an input transaction.
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_TOGGLE = 2'd1,
        CMD_STEP   = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    // Controller to datapath commands.
    typedef struct packed {
        logic latch;       // capture the accepted input transaction
        logic clear;       // mark every row dead
        logic cell_rd;     // issue the read of the addressed row
        logic cell_fin;    // finish a toggle or read with the returned row
        logic sweep_init;  // reset the line buffers and the row counter
        logic sweep_run;   // advance the generation sweep by one row
        logic out_load;    // move the pending result into the output register
    } t_ctl_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic sweep_last;  // the current sweep cycle writes the last row
        logic out_free;    // the output register can take a result this cycle
    } t_ctl_sts;

endpackage

// ----- design/lgs_in_if.sv -----
// Input channel interface: one command transaction per handshake.
`timescale 1ns / 1ps

interface lgs_in_if;
    logic                      valid;
    logic                      ready;
    logic [lgs_pkg::CMD_W-1:0] cmd;
    logic [lgs_pkg::COL_W-1:0] col;
    logic [lgs_pkg::ROW_W-1:0] row;

    modport source (output valid, output cmd, output col, output row, input ready);
    modport sink   (input valid, input cmd, input col, input row, output ready);
endinterface

// ----- design/lgs_out_if.sv -----
// Output channel interface: one result transaction per command.
`timescale 1ns / 1ps

interface lgs_out_if;
    logic valid;
    logic ready;
    logic alive;

    modport source (output valid, output alive, input ready);
    modport sink   (input valid, input alive, output ready);
endinterface

// ----- design/lgs_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module lgs_ram #(
    parameter int WIDTH = lgs_pkg::COLS_DEF,
    parameter int DEPTH = lgs_pkg::ROWS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/lgs_ctrl.sv -----
// Controller state machine: sequences commands, cell access and the generation sweep.
`timescale 1ns / 1ps

module lgs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  lgs_pkg::t_cmd     i_cmd,
    input  lgs_pkg::t_ctl_sts i_sts,
    output logic              o_in_ready,
    output lgs_pkg::t_ctl_cmd o_ctl
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_CELL  = 5'b00100,
        S_SWEEP = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.latch = 1'b1;
                    case (i_cmd)
                        lgs_pkg::CMD_CLEAR: begin
                            o_ctl.clear = 1'b1;
                            n_state     = S_DONE;
                        end
                        lgs_pkg::CMD_STEP: begin
                            o_ctl.sweep_init = 1'b1;
                            n_state          = S_SWEEP;
                        end
                        lgs_pkg::CMD_TOGGLE, lgs_pkg::CMD_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_ctl.cell_rd = 1'b1;
                n_state       = S_CELL;
            end
            S_CELL: begin
                o_ctl.cell_fin = 1'b1;
                n_state        = S_DONE;
            end
            S_SWEEP: begin
                o_ctl.sweep_run = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/lgs_dp.sv -----
// Datapath: grid memory, row valid bits, line buffers, B3/S23 rule and output register.
`timescale 1ns / 1ps

module lgs_dp #(
    parameter int COLS = lgs_pkg::COLS_DEF,
    parameter int ROWS = lgs_pkg::ROWS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lgs_pkg::t_ctl_cmd         i_ctl,
    input  lgs_pkg::t_cmd             i_cmd,
    input  logic [lgs_pkg::COL_W-1:0] i_col,
    input  logic [lgs_pkg::ROW_W-1:0] i_row,
    input  logic                      i_out_ready,
    output lgs_pkg::t_ctl_sts         o_sts,
    output logic                      o_out_valid,
    output logic                      o_out_alive
);

    localparam int AW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam int TW = $clog2(ROWS + 2);

    // Latched transaction.
    lgs_pkg::t_cmd             r_op;
    logic [lgs_pkg::COL_W-1:0] r_col;
    logic [lgs_pkg::ROW_W-1:0] r_row;
    logic                      r_inside;

    // Row valid bits; a row that is not valid reads as all dead.
    logic [ROWS-1:0] r_row_vld;
    logic            r_rd_vld;

    // Sweep counter and line buffers.
    logic [TW-1:0]   r_t;
    logic [COLS-1:0] r_prev;
    logic [COLS-1:0] r_cur;

    logic r_pend;
    logic r_out_vld;
    logic r_out_alive;

    // Memory ports.
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [COLS-1:0] ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [COLS-1:0] ram_rdata;

    logic [AW-1:0]   w_row_a;
    logic [CW-1:0]   w_col_i;
    logic [COLS-1:0] w_rd_row;
    logic [COLS-1:0] w_mask;
    logic [COLS-1:0] w_cell_new;
    logic            w_alive;
    logic [COLS-1:0] w_nxt;
    logic [COLS+1:0] w_pad_p;
    logic [COLS+1:0] w_pad_c;
    logic [COLS+1:0] w_pad_n;
    logic [COLS-1:0] w_gen;
    logic            w_sweep_rd;
    logic            w_sweep_wr;

    // Population count of the eight neighbors.
    function automatic logic [3:0] f_count8(input logic [7:0] bits);
        logic [3:0] sum;
        sum = 4'd0;
        for (int k = 0; k < 8; k++) begin
            sum = sum + {3'd0, bits[k]};
        end
        return sum;
    endfunction

    lgs_ram #(
        .WIDTH(COLS),
        .DEPTH(ROWS)
    ) u_grid_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Capture the accepted transaction and check the address against the grid.
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_op     <= i_cmd;
            r_col    <= i_col;
            r_row    <= i_row;
            r_inside <= (int'(i_col) < COLS) && (int'(i_row) < ROWS);
        end
    end

    assign w_row_a  = AW'(r_row);
    assign w_col_i  = CW'(r_col);
    assign w_rd_row = r_rd_vld ? ram_rdata : '0;

    // Single cell toggle and read.
    assign w_mask     = {{(COLS-1){1'b0}}, 1'b1} << w_col_i;
    assign w_cell_new = w_rd_row ^ w_mask;
    assign w_alive    = r_inside &&
                        ((r_op == lgs_pkg::CMD_TOGGLE) ? w_cell_new[w_col_i]
                                                       : w_rd_row[w_col_i]);

    // Sweep: read row t, write the new row t-2 from the line buffers.
    assign w_sweep_rd = i_ctl.sweep_run && (r_t < TW'(ROWS));
    assign w_sweep_wr = i_ctl.sweep_run && (r_t >= TW'(2));
    assign w_nxt      = ((r_t >= TW'(1)) && (r_t <= TW'(ROWS))) ? w_rd_row : '0;

    assign w_pad_p = {1'b0, r_prev, 1'b0};
    assign w_pad_c = {1'b0, r_cur, 1'b0};
    assign w_pad_n = {1'b0, w_nxt, 1'b0};

    // Apply the rule to every column of the middle row.
    always_comb begin
        logic [3:0] cnt;
        cnt   = 4'd0;
        w_gen = '0;
        for (int c = 0; c < COLS; c++) begin
            cnt = f_count8({w_pad_p[c], w_pad_p[c+1], w_pad_p[c+2],
                            w_pad_c[c],               w_pad_c[c+2],
                            w_pad_n[c], w_pad_n[c+1], w_pad_n[c+2]});
            w_gen[c] = (cnt == lgs_pkg::LIFE_BIRTH) ||
                       (w_pad_c[c+1] && (cnt == lgs_pkg::LIFE_SURVIVE));
        end
    end

    // Memory port selection.
    always_comb begin
        ram_re    = (i_ctl.cell_rd && r_inside) || w_sweep_rd;
        ram_raddr = i_ctl.cell_rd ? w_row_a : AW'(r_t);
        ram_we    = 1'b0;
        ram_waddr = w_row_a;
        ram_wdata = w_cell_new;
        if (w_sweep_wr) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(r_t - TW'(2));
            ram_wdata = w_gen;
        end else if (i_ctl.cell_fin && r_inside && (r_op == lgs_pkg::CMD_TOGGLE)) begin
            ram_we = 1'b1;
        end
    end

    // Row valid bits: cleared by reset and by a clear command, set on each write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_ctl.clear) begin
            r_row_vld <= '0;
        end else if (ram_we) begin
            r_row_vld[ram_waddr] <= 1'b1;
        end
    end

    // Valid flag that travels with the registered read data.
    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_rd_vld <= r_row_vld[ram_raddr];
        end
    end

    // Sweep counter and line buffers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.sweep_init) begin
            r_t    <= '0;
            r_prev <= '0;
            r_cur  <= '0;
        end else if (i_ctl.sweep_run) begin
            r_t    <= r_t + TW'(1);
            r_prev <= r_cur;
            r_cur  <= w_nxt;
        end
    end

    // Pending result of the current transaction.
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_pend <= 1'b0;
        end else if (i_ctl.cell_fin) begin
            r_pend <= w_alive;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_alive <= r_pend;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_out_alive      = r_out_alive;
    assign o_sts.out_free   = !r_out_vld || i_out_ready;
    assign o_sts.sweep_last = (r_t == TW'(ROWS + 1));

`ifndef NO_ASSERTIONS
    // A sweep never writes the row it is reading.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("grid RAM read and write at the same row");

    // A clear leaves every row dead.
    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> (r_row_vld == '0))
        else $error("row valid bits not cleared");

    // Outside a sweep only an in-grid toggle writes the grid.
    a_cell_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && !i_ctl.sweep_run) |-> ((r_op == lgs_pkg::CMD_TOGGLE) && r_inside))
        else $error("unexpected grid write");
`endif

endmodule

// ----- design/life_grid_generation_step_core.sv -----
// Top level of the life grid step core: controller, datapath and channel interfaces.
//
//  Channel | Dir | Fields         | Transaction
//  i_item  | in  | cmd, col, row  | one command (clear, toggle, step, read)
//  o_res   | out | alive          | one result per command
//
// A clear passes through DONE, a toggle or read through READ, CELL and DONE, a generation step
// through SWEEP and DONE: the sweep reads one grid row per cycle from the single read port.
// Synchronous active-low reset marks every row dead through per-row valid bits.
// A new command is taken only when the previous one has moved into the output
// register; that register may still wait for o_res.ready while the next command runs.
`timescale 1ns / 1ps

module life_grid_generation_step_core #(
    parameter int COLS = lgs_pkg::COLS_DEF,
    parameter int ROWS = lgs_pkg::ROWS_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    lgs_in_if.sink   i_item,
    lgs_out_if.source o_res
);

    lgs_pkg::t_ctl_cmd ctl;
    lgs_pkg::t_ctl_sts sts;
    lgs_pkg::t_cmd     in_cmd;

    assign in_cmd = lgs_pkg::t_cmd'(i_item.cmd);

    lgs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_item.valid),
        .i_cmd     (in_cmd),
        .i_sts     (sts),
        .o_in_ready(i_item.ready),
        .o_ctl     (ctl)
    );

    lgs_dp #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_cmd      (in_cmd),
        .i_col      (i_item.col),
        .i_row      (i_item.row),
        .i_out_ready(o_res.ready),
        .o_sts      (sts),
        .o_out_valid(o_res.valid),
        .o_out_alive(o_res.alive)
    );

endmodule

// ----- verif/tb_life_grid_generation_step_core.sv -----
// Self-checking testbench of the life grid step core with a B3/S23 grid predictor.
`timescale 1ns / 1ps

module tb_life_grid_generation_step_core;

    localparam int COLS = lgs_pkg::COLS_DEF;
    localparam int ROWS = lgs_pkg::ROWS_DEF;

    // Run shape.
    localparam int RANDOM_ITEMS   = 850;
    localparam int IDLE_PCT       = 26;
    localparam int QUIET_FIRST    = 300;
    localparam int QUIET_LAST     = 450;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RESET_CYCLES   = 6;

    typedef struct packed {
        lgs_pkg::t_cmd             cmd;
        logic [lgs_pkg::COL_W-1:0] col;
        logic [lgs_pkg::ROW_W-1:0] row;
    } t_life_cmd;

    logic i_clk;
    logic i_rst_n;

    lgs_in_if  in_if ();
    lgs_out_if out_if ();

    life_grid_generation_step_core #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (in_if.sink),
        .o_res  (out_if.source)
    );

    // Commands waiting to be driven and alive values waiting to come out.
    t_life_cmd   pending_cmds[$];
    bit          alive_expected[$];

    // Predicted grid: bit c of life_grid[r] is the cell at column c, row r.
    logic [COLS-1:0] life_grid [ROWS];

    int  error_count;
    int  accepted_count;
    int  cycle_count;
    logic item_taken;

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Cells outside the grid always count as dead.
    function automatic bit life_cell(int r, int c);
        if (r < 0 || r >= ROWS || c < 0 || c >= COLS) return 1'b0;
        return life_grid[r][c];
    endfunction

    // One generation over the old grid, then replace it as a whole.
    function automatic void advance_life();
        logic [COLS-1:0] next_grid [ROWS];
        int n;
        bit self_live;
        for (int r = 0; r < ROWS; r++) begin
            next_grid[r] = '0;
            for (int c = 0; c < COLS; c++) begin
                n = 0;
                self_live = life_cell(r, c);
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0) n += life_cell(r + dr, c + dc);
                    end
                end
                if (n == int'(lgs_pkg::LIFE_BIRTH) ||
                    (self_live && n == int'(lgs_pkg::LIFE_SURVIVE)))
                    next_grid[r][c] = 1'b1;
            end
        end
        for (int r = 0; r < ROWS; r++) life_grid[r] = next_grid[r];
    endfunction

    // Applies one command to the predicted grid and returns the expected alive bit.
    function automatic bit apply_life_cmd(t_life_cmd item);
        bit on_grid;
        bit alive;
        on_grid = (item.col < COLS) && (item.row < ROWS);
        alive   = 1'b0;
        case (item.cmd)
            lgs_pkg::CMD_CLEAR: begin
                for (int r = 0; r < ROWS; r++) life_grid[r] = '0;
            end
            lgs_pkg::CMD_TOGGLE: begin
                if (on_grid) begin
                    life_grid[item.row][item.col] = ~life_grid[item.row][item.col];
                    alive = life_grid[item.row][item.col];
                end
            end
            lgs_pkg::CMD_STEP: begin
                advance_life();
            end
            default: begin
                if (on_grid) alive = life_grid[item.row][item.col];
            end
        endcase
        return alive;
    endfunction

    // Random idling, switched off for a stretch in the middle of the run.
    function automatic bit roll_idle();
        if (accepted_count >= QUIET_FIRST && accepted_count < QUIET_LAST) return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    task automatic push_cmd(lgs_pkg::t_cmd cmd, int col, int row);
        t_life_cmd item;
        item.cmd = cmd;
        item.col = lgs_pkg::COL_W'(col);
        item.row = lgs_pkg::ROW_W'(row);
        pending_cmds.push_back(item);
    endtask

    // Input driver: presents the next command at the falling edge once the last one is taken.
    always @(negedge i_clk) begin : drive_proc
        t_life_cmd nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || item_taken) begin
            if (pending_cmds.size() != 0 && !roll_idle()) begin
                nxt = pending_cmds.pop_front();
                in_if.valid <= 1'b1;
                in_if.cmd   <= nxt.cmd;
                in_if.col   <= nxt.col;
                in_if.row   <= nxt.row;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Output back-pressure.
    always @(negedge i_clk) begin
        if (!i_rst_n) out_if.ready <= 1'b0;
        else          out_if.ready <= !roll_idle();
    end

    // Monitor: predicts each accepted command, then checks each result transaction.
    always @(posedge i_clk) begin : monitor_proc
        t_life_cmd taken;
        bit        want;
        bit        took;
        took = i_rst_n && in_if.valid && in_if.ready;
        if (took) begin
            taken.cmd = lgs_pkg::t_cmd'(in_if.cmd);
            taken.col = in_if.col;
            taken.row = in_if.row;
            alive_expected.push_back(apply_life_cmd(taken));
            accepted_count <= accepted_count + 1;
        end
        item_taken <= took;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (alive_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none actual alive=%0b",
                         $time, out_if.alive);
                error_count++;
            end else begin
                want = alive_expected.pop_front();
                if (out_if.alive !== want) begin
                    $display("%0t: alive mismatch, expected %0b actual %0b",
                             $time, want, out_if.alive);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     alive_expected.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stim_proc
        int start_size;
        int c0;
        int r0;
        int span;
        int n_toggle;
        int n_step;
        int n_read;
        int col;
        int row;

        i_rst_n     = 1'b0;
        in_if.valid = 1'b0;
        in_if.cmd   = lgs_pkg::CMD_CLEAR;
        in_if.col   = '0;
        in_if.row   = '0;
        out_if.ready = 1'b0;
        item_taken  = 1'b0;
        error_count = 0;
        accepted_count = 0;
        cycle_count = 0;
        for (int r = 0; r < ROWS; r++) life_grid[r] = '0;

        // Directed part: reset state, corners, addresses off the grid, edges without wrap.
        push_cmd(lgs_pkg::CMD_READ,   0, 0);
        push_cmd(lgs_pkg::CMD_TOGGLE, 0, 0);
        push_cmd(lgs_pkg::CMD_TOGGLE, COLS - 1, ROWS - 1);
        push_cmd(lgs_pkg::CMD_TOGGLE, 31, 15);
        push_cmd(lgs_pkg::CMD_READ,   31, 15);
        push_cmd(lgs_pkg::CMD_TOGGLE, COLS, 0);
        push_cmd(lgs_pkg::CMD_READ,   COLS - 1, ROWS - 1);
        push_cmd(lgs_pkg::CMD_STEP,   0, 0);
        push_cmd(lgs_pkg::CMD_READ,   0, 0);
        push_cmd(lgs_pkg::CMD_CLEAR,  0, 0);
        // Blinker lying on the top edge.
        push_cmd(lgs_pkg::CMD_TOGGLE, 10, 0);
        push_cmd(lgs_pkg::CMD_TOGGLE, 11, 0);
        push_cmd(lgs_pkg::CMD_TOGGLE, 12, 0);
        push_cmd(lgs_pkg::CMD_STEP,   0, 0);
        push_cmd(lgs_pkg::CMD_READ,   11, 1);
        // Block in the bottom right corner.
        push_cmd(lgs_pkg::CMD_TOGGLE, COLS - 2, ROWS - 2);
        push_cmd(lgs_pkg::CMD_TOGGLE, COLS - 1, ROWS - 2);
        push_cmd(lgs_pkg::CMD_TOGGLE, COLS - 2, ROWS - 1);
        push_cmd(lgs_pkg::CMD_TOGGLE, COLS - 1, ROWS - 1);
        push_cmd(lgs_pkg::CMD_STEP,   0, 0);
        push_cmd(lgs_pkg::CMD_READ,   COLS - 1, ROWS - 1);
        push_cmd(lgs_pkg::CMD_READ,   31, 0);
        push_cmd(lgs_pkg::CMD_CLEAR,  31, 15);
        push_cmd(lgs_pkg::CMD_READ,   COLS - 1, ROWS - 1);
        push_cmd(lgs_pkg::CMD_STEP,   0, 0);

        // Random part: seed a patch, run a few generations and probe around it.
        start_size = pending_cmds.size();
        while (pending_cmds.size() - start_size < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 15) push_cmd(lgs_pkg::CMD_CLEAR,
                                                     $urandom_range(0, 31),
                                                     $urandom_range(0, 15));
            c0       = $urandom_range(0, COLS - 1);
            r0       = $urandom_range(0, ROWS - 1);
            span     = $urandom_range(2, 7);
            n_toggle = $urandom_range(3, 14);
            for (int i = 0; i < n_toggle; i++) begin
                col = (c0 + $urandom_range(0, span)) % 32;
                row = (r0 + $urandom_range(0, span)) % ROWS;
                push_cmd(lgs_pkg::CMD_TOGGLE, col, row);
            end
            n_step = $urandom_range(1, 4);
            for (int s = 0; s < n_step; s++) begin
                push_cmd(lgs_pkg::CMD_STEP, $urandom_range(0, 31), $urandom_range(0, 15));
                n_read = $urandom_range(1, 4);
                for (int i = 0; i < n_read; i++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        col = $urandom_range(0, 31);
                        row = $urandom_range(0, 15);
                    end else begin
                        col = (c0 + $urandom_range(0, span + 2) + 31) % 32;
                        row = (r0 + $urandom_range(0, span + 2) + 15) % 16;
                    end
                    push_cmd(lgs_pkg::CMD_READ, col, row);
                end
            end
            // Occasional noise of fully random commands.
            if ($urandom_range(0, 9) == 0) begin
                for (int i = 0; i < 4; i++)
                    push_cmd(lgs_pkg::t_cmd'($urandom_range(0, 3)), $urandom_range(0, 31),
                             $urandom_range(0, 15));
            end
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Drain: wait until everything is sent and received, then idle for DRAIN_CYCLES.
        @(posedge i_clk);
        while (pending_cmds.size() != 0 || in_if.valid || alive_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && alive_expected.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- life_grid_generation_step_core.f -----
design/lgs_pkg.sv
design/lgs_in_if.sv
design/lgs_out_if.sv
design/lgs_ram.sv
design/lgs_ctrl.sv
design/lgs_dp.sv
design/life_grid_generation_step_core.sv
verif/tb_life_grid_generation_step_core.sv
